// ===== design/npar_pkg.sv =====
// ----------------------------------------------------------------------------
// Note parser package
// Shared types, constants and helper functions for the note token parser.
// ----------------------------------------------------------------------------
package npar_pkg;

  // Width of the modifier number accumulator; numbers saturate at its maximum.
  localparam int NUM_WIDTH = 32;
  localparam logic [NUM_WIDTH-1:0] NUM_MAX = '1;
  localparam logic [NUM_WIDTH-1:0] NUM_MAX_DIV10 = NUM_MAX / 10;
  localparam logic [3:0] NUM_MAX_MOD10 = 4'(NUM_MAX % 10);

  // Configuration register indexes and reset values.
  localparam logic REG_DEFAULT_OCTAVE = 1'b0;
  localparam logic [3:0] DEFAULT_OCTAVE_RESET = 4'd4;

  // Parser phases.
  localparam logic [3:0] PH_LETTER  = 4'd0;
  localparam logic [3:0] PH_ACC1    = 4'd1;
  localparam logic [3:0] PH_ACC2    = 4'd2;
  localparam logic [3:0] PH_ACC3    = 4'd3;
  localparam logic [3:0] PH_OCTSKIP = 4'd4;
  localparam logic [3:0] PH_OCTDIG  = 4'd5;
  localparam logic [3:0] PH_MOD     = 4'd6;
  localparam logic [3:0] PH_NUMSKIP = 4'd7;
  localparam logic [3:0] PH_NUMDIG  = 4'd8;
  localparam logic [3:0] PH_DONE    = 4'd9;
  localparam logic [3:0] PH_ERR     = 4'd10;

  // Value slots written by modifiers.
  localparam int NUM_VALUES = 6;
  localparam logic [2:0] V_TIME   = 3'd0;
  localparam logic [2:0] V_DELAY  = 3'd1;
  localparam logic [2:0] V_PDELAY = 3'd2;
  localparam logic [2:0] V_PDIV   = 3'd3;
  localparam logic [2:0] V_PTIME  = 3'd4;
  localparam logic [2:0] V_VOLUME = 3'd5;

  // Status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_BAD   = 2'd2;

  // Characters of the token grammar.
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_G = 8'h47;
  localparam logic [7:0] CH_CASE_MASK = 8'hDF;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  // Parser state carried from one word to the next.
  typedef struct packed {
    logic [3:0]                  phase;
    logic [11:0]                 pitch_acc;
    logic [7:0]                  octave_acc;
    logic                        octave_seen;
    logic [NUM_WIDTH-1:0]        number_acc;
    logic [2:0]                  target;
    logic [NUM_VALUES-1:0][31:0] values;
    logic                        natural_mark;
    logic                        endless_mark;
  } state_t;

  // One decoded note.
  typedef struct packed {
    logic [11:0] pitch;
    logic [31:0] volume;
    logic [31:0] time_ms;
    logic [31:0] delay_ms;
    logic [31:0] part_delay;
    logic [31:0] part_div;
    logic [31:0] part_time;
    logic        natural_mark;
    logic        endless_mark;
    logic [1:0]  status;
  } result_t;

  // State at the start of every token.
  function automatic state_t clear_state();
    state_t s;
    s = '0;
    s.phase = PH_LETTER;
    s.values[V_PDIV] = 32'd1;
    s.values[V_VOLUME] = '1;
    return s;
  endfunction

  // Low 32 bits of an accumulator value, zero extended when it is narrower.
  function automatic logic [31:0] to_word(input logic [NUM_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  // Semitone of a note letter, indexed from A.
  function automatic logic [3:0] semitone(input logic [2:0] idx);
    logic [3:0] r;
    unique case (idx)
      3'd0:    r = 4'd9;
      3'd1:    r = 4'd11;
      3'd2:    r = 4'd0;
      3'd3:    r = 4'd2;
      3'd4:    r = 4'd4;
      3'd5:    r = 4'd5;
      3'd6:    r = 4'd7;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/npar_decode.sv =====
// ----------------------------------------------------------------------------
// Note parser character decoder
// Computes the next parser state for one word and, at the end of a token,
// the decoded note.
// ----------------------------------------------------------------------------
module npar_decode (
  input  npar_pkg::state_t  st,
  input  logic [7:0]        ch,
  input  logic              has_char,
  input  logic              is_last,
  input  logic [3:0]        default_octave,
  output npar_pkg::state_t  st_next,
  output npar_pkg::result_t res
);

  logic                           letter_ok;
  logic [7:0]                     letter_up;
  logic [7:0]                     letter_off;
  logic                           is_digit;
  logic [3:0]                     digit;
  logic                           is_blank;
  logic [11:0]                    oct_ext;
  logic [11:0]                    oct_mac;
  logic [7:0]                     oct_sat;
  logic                           num_over;
  logic [npar_pkg::NUM_WIDTH-1:0] num_mac;
  logic [11:0]                    oct_plus1;
  logic [11:0]                    oct_pitch;
  logic [7:0]                     oct_used;
  logic [7:0]                     ch_off;
  npar_pkg::state_t               s;
  logic [3:0]                     ph;
  logic                           fin;
  logic [1:0]                     status;

  // Write a value into the slot chosen by the last modifier.
  function automatic npar_pkg::state_t store(input npar_pkg::state_t x,
                                             input logic [31:0] v);
    npar_pkg::state_t y;
    y = x;
    for (int i = 0; i < npar_pkg::NUM_VALUES; i++) begin
      if (x.target == 3'(i)) begin
        y.values[i] = v;
      end
    end
    return y;
  endfunction

  // Character classes.
  assign letter_up  = ch & npar_pkg::CH_CASE_MASK;
  assign letter_ok  = (letter_up >= npar_pkg::CH_UPPER_A) &&
                      (letter_up <= npar_pkg::CH_UPPER_G);
  assign letter_off = letter_up - npar_pkg::CH_UPPER_A;
  assign is_digit   = (ch >= npar_pkg::CH_ZERO) && (ch <= npar_pkg::CH_NINE);
  assign ch_off     = ch - npar_pkg::CH_ZERO;
  assign digit      = ch_off[3:0];
  assign is_blank   = (ch == npar_pkg::CH_SPACE) || (ch == npar_pkg::CH_TAB) ||
                      (ch == npar_pkg::CH_LF) || (ch == npar_pkg::CH_VT) ||
                      (ch == npar_pkg::CH_FF) || (ch == npar_pkg::CH_CR);

  // Octave digit step, saturating at 255.
  assign oct_ext = 12'(st.octave_acc);
  assign oct_mac = (oct_ext << 3) + (oct_ext << 1) + 12'(digit);
  assign oct_sat = (oct_mac > 12'd255) ? 8'd255 : oct_mac[7:0];

  // Modifier digit step: acc*10 + d exceeds the maximum exactly when acc is
  // above max/10, or equal to it with d above the remainder.
  assign num_over = (st.number_acc > npar_pkg::NUM_MAX_DIV10) ||
                    ((st.number_acc == npar_pkg::NUM_MAX_DIV10) &&
                     (digit > npar_pkg::NUM_MAX_MOD10));
  assign num_mac  = (st.number_acc << 3) + (st.number_acc << 1) +
                    npar_pkg::NUM_WIDTH'(digit);

  // Character parse; each phase may hand the character on to the next.
  always_comb begin
    s         = st;
    ph        = st.phase;
    fin       = 1'b0;
    status    = npar_pkg::STATUS_OK;
    res       = '0;
    oct_used  = 8'd0;
    oct_plus1 = 12'd0;
    oct_pitch = 12'd0;

    if (has_char) begin
      if (ph == npar_pkg::PH_LETTER) begin
        if (letter_ok) begin
          s.pitch_acc = 12'(npar_pkg::semitone(letter_off[2:0]));
          ph = npar_pkg::PH_ACC1;
        end else begin
          ph = npar_pkg::PH_ERR;
        end
        fin = 1'b1;
      end

      // Sharp, then flat, then natural mark.
      if (!fin && ph == npar_pkg::PH_ACC1) begin
        ph = npar_pkg::PH_ACC2;
        if (ch == npar_pkg::CH_HASH) begin
          s.pitch_acc = s.pitch_acc + 12'd1;
          fin = 1'b1;
        end
      end
      if (!fin && ph == npar_pkg::PH_ACC2) begin
        ph = npar_pkg::PH_ACC3;
        if (ch == npar_pkg::CH_LOWER_B || ch == npar_pkg::CH_AMP) begin
          s.pitch_acc = s.pitch_acc - 12'd1;
          fin = 1'b1;
        end
      end
      if (!fin && ph == npar_pkg::PH_ACC3) begin
        ph = npar_pkg::PH_OCTSKIP;
        if (ch == npar_pkg::CH_LOWER_N) begin
          s.natural_mark = 1'b1;
          fin = 1'b1;
        end
      end

      // Octave digits after optional blanks.
      if (!fin && ph == npar_pkg::PH_OCTSKIP) begin
        if (is_blank) begin
          fin = 1'b1;
        end else if (is_digit) begin
          s.octave_acc = 8'(digit);
          s.octave_seen = 1'b1;
          ph = npar_pkg::PH_OCTDIG;
          fin = 1'b1;
        end else begin
          ph = npar_pkg::PH_MOD;
        end
      end else if (!fin && ph == npar_pkg::PH_OCTDIG) begin
        if (is_digit) begin
          s.octave_acc = oct_sat;
          fin = 1'b1;
        end else begin
          ph = npar_pkg::PH_MOD;
        end
      end

      // Modifier number: blanks, then digits.
      if (!fin && ph == npar_pkg::PH_NUMSKIP) begin
        if (is_blank) begin
          fin = 1'b1;
        end else if (is_digit) begin
          s.number_acc = npar_pkg::NUM_WIDTH'(digit);
          ph = npar_pkg::PH_NUMDIG;
          fin = 1'b1;
        end else begin
          s = store(s, 32'd0);
          ph = npar_pkg::PH_DONE;
          fin = 1'b1;
        end
      end
      if (!fin && ph == npar_pkg::PH_NUMDIG) begin
        if (is_digit) begin
          s.number_acc = num_over ? npar_pkg::NUM_MAX : num_mac;
          fin = 1'b1;
        end else begin
          s = store(s, npar_pkg::to_word(s.number_acc));
          ph = npar_pkg::PH_MOD;
        end
      end

      // Modifier characters.
      if (!fin && ph == npar_pkg::PH_MOD) begin
        unique case (ch)
          npar_pkg::CH_SPACE, npar_pkg::CH_TAB: begin
            ph = npar_pkg::PH_DONE;
          end
          npar_pkg::CH_AT: begin
            s.target = npar_pkg::V_TIME;
            s.number_acc = '0;
            ph = npar_pkg::PH_NUMSKIP;
          end
          npar_pkg::CH_PERCENT: begin
            s.target = npar_pkg::V_DELAY;
            s.number_acc = '0;
            ph = npar_pkg::PH_NUMSKIP;
          end
          npar_pkg::CH_PLUS: begin
            s.target = npar_pkg::V_PDELAY;
            s.number_acc = '0;
            ph = npar_pkg::PH_NUMSKIP;
          end
          npar_pkg::CH_SLASH: begin
            s.target = npar_pkg::V_PDIV;
            s.number_acc = '0;
            ph = npar_pkg::PH_NUMSKIP;
          end
          npar_pkg::CH_COLON: begin
            s.target = npar_pkg::V_PTIME;
            s.number_acc = '0;
            ph = npar_pkg::PH_NUMSKIP;
          end
          npar_pkg::CH_BANG: begin
            s.target = npar_pkg::V_VOLUME;
            s.number_acc = '0;
            ph = npar_pkg::PH_NUMSKIP;
          end
          npar_pkg::CH_DOT: begin
            s.endless_mark = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
    s.phase = ph;

    // End of token: close an open number and build the note.
    if (is_last) begin
      if (ph == npar_pkg::PH_NUMSKIP) begin
        s = store(s, 32'd0);
      end else if (ph == npar_pkg::PH_NUMDIG) begin
        s = store(s, npar_pkg::to_word(s.number_acc));
      end

      if (ph == npar_pkg::PH_LETTER) begin
        status = npar_pkg::STATUS_EMPTY;
      end else if (ph == npar_pkg::PH_ERR) begin
        status = npar_pkg::STATUS_BAD;
      end

      if (status != npar_pkg::STATUS_OK) begin
        s = npar_pkg::clear_state();
        res.pitch = 12'd0;
      end else begin
        // Pitch offset of the octave in use: (octave + 1) * 12.
        oct_used  = s.octave_seen ? s.octave_acc : 8'(default_octave);
        oct_plus1 = 12'(oct_used) + 12'd1;
        oct_pitch = (oct_plus1 << 3) + (oct_plus1 << 2);
        res.pitch = s.pitch_acc + oct_pitch;
      end
      res.volume       = s.values[npar_pkg::V_VOLUME];
      res.time_ms      = s.values[npar_pkg::V_TIME];
      res.delay_ms     = s.values[npar_pkg::V_DELAY];
      res.part_delay   = s.values[npar_pkg::V_PDELAY];
      res.part_div     = s.values[npar_pkg::V_PDIV];
      res.part_time    = s.values[npar_pkg::V_PTIME];
      res.natural_mark = s.natural_mark;
      res.endless_mark = s.endless_mark;
      res.status       = status;
      st_next = npar_pkg::clear_state();
    end else begin
      st_next = s;
    end
  end

endmodule

// ===== design/npar_out_queue.sv =====
// ----------------------------------------------------------------------------
// Note parser output queue
// Result register with a skid entry behind it, so that the input keeps
// flowing while a decoded note waits to be taken.
// ----------------------------------------------------------------------------
module npar_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  npar_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output npar_pkg::result_t head
);

  logic              head_valid;
  logic              skid_valid;
  npar_pkg::result_t skid;
  logic              pop;

  assign pop       = head_valid && out_ready;
  assign full      = skid_valid;
  assign out_valid = head_valid;

  // Occupancy of the two entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      if (head_valid) begin
        skid_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end
  end

  // Payload: the skid entry moves up first, so words leave in order.
  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      head <= skid;
    end else if (push && (!head_valid || pop)) begin
      head <= push_data;
    end
    if (push && head_valid && !pop) begin
      skid <= push_data;
    end
  end

endmodule

// ===== design/note_text_parser.sv =====
// ----------------------------------------------------------------------------
// Note text parser
// Decodes a note token, one character per word, into pitch and modifiers.
// ----------------------------------------------------------------------------
// The parser takes one character word in every clock cycle while its output
// queue has room, with no bubble between tokens. The whole parse step for a
// character (phase update, octave and decimal accumulation with saturation,
// value slot write) is one layer of logic in front of the parser state
// registers, so the rate is one word per cycle. The word that carries is_last
// places the decoded note in the two-entry output queue behind the parser; the
// input stalls only when both entries hold notes that have not been taken.
// The default octave register is at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module note_text_parser (
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Character input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        has_char,
  input  logic        is_last,
  // Note output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] pitch,
  output logic [31:0] volume,
  output logic [31:0] time_ms,
  output logic [31:0] delay_ms,
  output logic [31:0] part_delay,
  output logic [31:0] part_div,
  output logic [31:0] part_time,
  output logic        natural_mark,
  output logic        endless_mark,
  output logic [1:0]  status
);

  logic [3:0]        default_octave;
  npar_pkg::state_t  st;
  npar_pkg::state_t  st_next;
  npar_pkg::result_t res;
  npar_pkg::result_t head;
  logic              accept;
  logic              q_full;
  logic              cfg_write;

  // Configuration register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_octave <= npar_pkg::DEFAULT_OCTAVE_RESET;
    end else if (cfg_write && paddr[2] == npar_pkg::REG_DEFAULT_OCTAVE) begin
      default_octave <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == npar_pkg::REG_DEFAULT_OCTAVE) ?
                  {28'd0, default_octave} : 32'd0;

  // Parser state advances on every accepted word.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= npar_pkg::clear_state();
    end else if (accept) begin
      st <= st_next;
    end
  end

  npar_decode u_decode (
    .st             (st),
    .ch             (ch),
    .has_char       (has_char),
    .is_last        (is_last),
    .default_octave (default_octave),
    .st_next        (st_next),
    .res            (res)
  );

  // Decoded notes are queued for the output channel.
  npar_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && is_last),
    .push_data (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign pitch        = head.pitch;
  assign volume       = head.volume;
  assign time_ms      = head.time_ms;
  assign delay_ms     = head.delay_ms;
  assign part_delay   = head.part_delay;
  assign part_div     = head.part_div;
  assign part_time    = head.part_time;
  assign natural_mark = head.natural_mark;
  assign endless_mark = head.endless_mark;
  assign status       = head.status;

endmodule
